FILE: rtl/thn_pkg.sv
// ----------------------------------------------------------------------------
// thn_pkg: shared types and constants for the top-N largest min-heap
// Holds the heap entry layout, build depth, opcode and compare mode codes.
// ----------------------------------------------------------------------------
package thn_pkg;

	localparam int MAX_KEPT  = 16;
	localparam int IDX_W     = $clog2(MAX_KEPT);
	localparam int CNT_W     = $clog2(MAX_KEPT + 1);
	localparam int CFG_W     = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(10);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CMP_UP,
		CMP_DOWN,
		CMP_REPLACE
	} cmp_mode_t;

	typedef struct packed {
		logic [47:0] mem_bytes;
		logic [31:0] key_tag;
		logic [7:0]  db_index;
		logic [3:0]  data_type;
		logic [31:0] item_count;
		logic [31:0] largest_element;
		logic        has_expiry;
		logic [47:0] expire_ms;
	} entry_t;

	typedef struct packed {
		logic move;
		logic pick_b;
	} cmp_res_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] ra0;
		logic [IDX_W-1:0] ra1;
		logic             we;
		logic [IDX_W-1:0] waddr;
	} ram_ctl_t;

endpackage

FILE: rtl/thn_item_if.sv
// ----------------------------------------------------------------------------
// thn_item_if: input item channel
// Valid/ready channel carrying one insert or drain request.
// ----------------------------------------------------------------------------
interface thn_item_if import thn_pkg::*; ();
	logic        valid;
	logic        ready;
	op_t         opcode;
	logic [47:0] mem_bytes;
	logic [31:0] key_tag;
	logic [7:0]  db_index;
	logic [3:0]  data_type;
	logic [31:0] item_count;
	logic [31:0] largest_element;
	logic        has_expiry;
	logic [47:0] expire_ms;

	modport source (
		output valid, opcode, mem_bytes, key_tag, db_index, data_type,
		       item_count, largest_element, has_expiry, expire_ms,
		input  ready
	);
	modport sink (
		input  valid, opcode, mem_bytes, key_tag, db_index, data_type,
		       item_count, largest_element, has_expiry, expire_ms,
		output ready
	);
endinterface

FILE: rtl/thn_result_if.sv
// ----------------------------------------------------------------------------
// thn_result_if: result channel
// Valid/ready channel carrying one drained heap entry and its last marker.
// ----------------------------------------------------------------------------
interface thn_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] out_mem_bytes;
	logic [31:0] out_key_tag;
	logic [7:0]  out_db_index;
	logic [3:0]  out_data_type;
	logic [31:0] out_item_count;
	logic [31:0] out_largest_element;
	logic        out_has_expiry;
	logic [47:0] out_expire_ms;
	logic        last;

	modport source (
		output valid, out_mem_bytes, out_key_tag, out_db_index, out_data_type,
		       out_item_count, out_largest_element, out_has_expiry,
		       out_expire_ms, last,
		input  ready
	);
	modport sink (
		input  valid, out_mem_bytes, out_key_tag, out_db_index, out_data_type,
		       out_item_count, out_largest_element, out_has_expiry,
		       out_expire_ms, last,
		output ready
	);
endinterface

FILE: rtl/thn_heap_ram.sv
// ----------------------------------------------------------------------------
// thn_heap_ram: heap entry storage
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module thn_heap_ram import thn_pkg::*; (
	input  logic     clk,
	input  ram_ctl_t ctl,
	input  entry_t   wdata,
	output entry_t   rd0,
	output entry_t   rd1
);
	entry_t mem_q [MAX_KEPT];
	entry_t rd0_q;
	entry_t rd1_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[ctl.waddr] <= wdata;
		end
		if (ctl.re) begin
			rd0_q <= mem_q[ctl.ra0];
			rd1_q <= mem_q[ctl.ra1];
		end
	end

	assign rd0 = rd0_q;
	assign rd1 = rd1_q;
endmodule

FILE: rtl/thn_sift_cmp.sv
// ----------------------------------------------------------------------------
// thn_sift_cmp: shared key comparator
// Decides one sift-up step, one sift-down step or the root replacement test.
// ----------------------------------------------------------------------------
module thn_sift_cmp import thn_pkg::*; (
	input  cmp_mode_t   mode,
	input  logic [47:0] cur_key,
	input  logic [47:0] a_key,
	input  logic [47:0] b_key,
	input  logic        a_ok,
	input  logic        b_ok,
	output cmp_res_t    res
);
	logic        a_less;
	logic [47:0] best_key;
	logic        b_less;

	// On equal children the left one wins, since the right must be strictly smaller.
	assign a_less   = a_ok && (a_key < cur_key);
	assign best_key = a_less ? a_key : cur_key;
	assign b_less   = b_ok && (b_key < best_key);

	always_comb begin
		res = '0;
		case (mode)
			CMP_UP: begin
				res.move = a_key > cur_key;
			end
			CMP_REPLACE: begin
				res.move = cur_key > a_key;
			end
			CMP_DOWN: begin
				res.move   = a_less || b_less;
				res.pick_b = b_less;
			end
			default: begin
				res = '0;
			end
		endcase
	end
endmodule

FILE: rtl/top_n_largest_min_heap_unit.sv
// ----------------------------------------------------------------------------
// top_n_largest_min_heap_unit: keeps the N largest records in a min-heap
// Insert items sift up, or replace the root and sift down, or are dropped;
// drain items pop the heap smallest first, marking the final entry with last.
// ----------------------------------------------------------------------------
// Insert: accept, then per heap level walked a read, then a compare and
// write, until the entry is placed; a replacement first compares the new
// entry with the root. Drain: per emitted entry a root read, an emit and a
// reload of the former last entry, then a read and a compare and write per
// level of sift down, stretched by output backpressure. One item at a time:
// the input is not ready until the current item finishes. Reset empties the
// heap and sets the capacity to 10; storage is not cleared.
module top_n_largest_min_heap_unit import thn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	thn_item_if.sink         item,
	thn_result_if.source     result
);
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_REP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DR_RD,
		ST_DR_EMIT,
		ST_DR_LOAD
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             draining_q;
	entry_t           cur_q;
	entry_t           out_q;
	logic             out_valid_q;
	logic             out_last_q;

	logic [CNT_W-1:0] cap_eff;
	logic             accept;
	logic             out_free;
	entry_t           in_entry;
	logic [IDX_W+1:0] l_pos;
	logic [IDX_W+1:0] r_pos;
	logic             l_ok;
	logic             r_ok;
	logic [IDX_W-1:0] parent_idx;
	logic [CNT_W-1:0] count_dec;

	ram_ctl_t         ram_ctl;
	entry_t           ram_wdata;
	entry_t           rd0;
	entry_t           rd1;
	cmp_mode_t        cmp_mode;
	cmp_res_t         cmp_res;

	assign cap_eff = (CNT_W'(cap_q) > CNT_W'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : CNT_W'(cap_q);
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign in_entry.mem_bytes       = item.mem_bytes;
	assign in_entry.key_tag         = item.key_tag;
	assign in_entry.db_index        = item.db_index;
	assign in_entry.data_type       = item.data_type;
	assign in_entry.item_count      = item.item_count;
	assign in_entry.largest_element = item.largest_element;
	assign in_entry.has_expiry      = item.has_expiry;
	assign in_entry.expire_ms       = item.expire_ms;

	assign l_pos      = {1'b0, idx_q, 1'b1};
	assign r_pos      = l_pos + (IDX_W+2)'(1);
	assign l_ok       = l_pos < (IDX_W+2)'(count_q);
	assign r_ok       = r_pos < (IDX_W+2)'(count_q);
	assign parent_idx = (idx_q - IDX_W'(1)) >> 1;
	assign count_dec  = count_q - CNT_W'(1);

	thn_heap_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.wdata (ram_wdata),
		.rd0   (rd0),
		.rd1   (rd1)
	);

	thn_sift_cmp u_cmp (
		.mode    (cmp_mode),
		.cur_key (cur_q.mem_bytes),
		.a_key   (rd0.mem_bytes),
		.b_key   (rd1.mem_bytes),
		.a_ok    (l_ok),
		.b_ok    (r_ok),
		.res     (cmp_res)
	);

	// The moving entry rides in cur_q; each step writes one entry into the hole.
	always_comb begin
		ram_ctl       = '0;
		ram_ctl.waddr = idx_q;
		ram_wdata     = cur_q;
		cmp_mode      = CMP_DOWN;
		case (state_q)
			ST_IDLE: begin
				ram_ctl.re = accept;
			end
			ST_UP_RD: begin
				if (idx_q != '0) begin
					ram_ctl.re  = 1'b1;
					ram_ctl.ra0 = parent_idx;
				end else begin
					ram_ctl.we = 1'b1;
				end
			end
			ST_UP_CMP: begin
				cmp_mode   = CMP_UP;
				ram_ctl.we = 1'b1;
				ram_wdata  = cmp_res.move ? rd0 : cur_q;
			end
			ST_REP_CMP: begin
				cmp_mode = CMP_REPLACE;
			end
			ST_DN_RD: begin
				if (l_ok) begin
					ram_ctl.re  = 1'b1;
					ram_ctl.ra0 = l_pos[IDX_W-1:0];
					ram_ctl.ra1 = r_ok ? r_pos[IDX_W-1:0] : l_pos[IDX_W-1:0];
				end else begin
					ram_ctl.we = 1'b1;
				end
			end
			ST_DN_CMP: begin
				cmp_mode   = CMP_DOWN;
				ram_ctl.we = 1'b1;
				if (cmp_res.move) begin
					ram_wdata = cmp_res.pick_b ? rd1 : rd0;
				end
			end
			ST_DR_RD: begin
				ram_ctl.re = 1'b1;
			end
			ST_DR_EMIT: begin
				if (out_free && count_q > CNT_W'(1)) begin
					ram_ctl.re  = 1'b1;
					ram_ctl.ra0 = count_dec[IDX_W-1:0];
				end
			end
			ST_DR_LOAD: begin
				ram_ctl.re = 1'b0;
			end
			default: begin
				ram_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			draining_q  <= 1'b0;
			cur_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// An emit in the same cycle refills the output register instead.
			if (result.valid && result.ready && state_q != ST_DR_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q <= in_entry;
						if (item.opcode == OP_INSERT) begin
							draining_q <= 1'b0;
							if (count_q < cap_eff) begin
								idx_q   <= count_q[IDX_W-1:0];
								count_q <= count_q + CNT_W'(1);
								state_q <= ST_UP_RD;
							end else if (count_q != '0) begin
								state_q <= ST_REP_CMP;
							end
						end else begin
							draining_q <= 1'b1;
							if (count_q != '0) begin
								state_q <= ST_DR_EMIT;
							end
						end
					end
				end
				ST_UP_RD: begin
					state_q <= (idx_q == '0) ? ST_IDLE : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (cmp_res.move) begin
						idx_q   <= parent_idx;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REP_CMP: begin
					if (cmp_res.move) begin
						idx_q   <= '0;
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DN_RD: begin
					if (l_ok) begin
						state_q <= ST_DN_CMP;
					end else begin
						state_q <= draining_q ? ST_DR_RD : ST_IDLE;
					end
				end
				ST_DN_CMP: begin
					if (cmp_res.move) begin
						idx_q   <= cmp_res.pick_b ? r_pos[IDX_W-1:0] : l_pos[IDX_W-1:0];
						state_q <= ST_DN_RD;
					end else begin
						state_q <= draining_q ? ST_DR_RD : ST_IDLE;
					end
				end
				ST_DR_RD: begin
					state_q <= ST_DR_EMIT;
				end
				ST_DR_EMIT: begin
					if (out_free) begin
						out_q       <= rd0;
						out_last_q  <= (count_q == CNT_W'(1));
						out_valid_q <= 1'b1;
						count_q     <= count_dec;
						state_q     <= (count_q == CNT_W'(1)) ? ST_IDLE : ST_DR_LOAD;
					end
				end
				ST_DR_LOAD: begin
					// The former last entry becomes the root and sinks from there.
					cur_q   <= rd0;
					idx_q   <= '0;
					state_q <= ST_DN_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid               = out_valid_q;
	assign result.out_mem_bytes       = out_q.mem_bytes;
	assign result.out_key_tag         = out_q.key_tag;
	assign result.out_db_index        = out_q.db_index;
	assign result.out_data_type       = out_q.data_type;
	assign result.out_item_count      = out_q.item_count;
	assign result.out_largest_element = out_q.largest_element;
	assign result.out_has_expiry      = out_q.has_expiry;
	assign result.out_expire_ms       = out_q.expire_ms;
	assign result.last                = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEPT))
		else $error("heap entry count exceeds the built depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP_RD || state_q == ST_DN_RD) |-> (CNT_W'(idx_q) < count_q))
		else $error("sift hole lies outside the kept entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DR_EMIT) |-> (count_q != '0))
		else $error("drain emit with an empty heap");
endmodule

FILE: dv/top_n_largest_min_heap_unit_test.sv
// ----------------------------------------------------------------------------
// top_n_largest_min_heap_unit_test: self-checking bench for the top-N heap
// Runs directed insert and drain sequences over the capacity limits, then
// random traffic under several idle and stall patterns and a long output
// hold-off. A mirror heap predicts every drained entry, which is compared
// field by field with each result transfer.
// ----------------------------------------------------------------------------
module top_n_largest_min_heap_unit_test;
	import thn_pkg::*;

	localparam int SETTLE_CYCLES    = 32;
	localparam int RANDOM_PER_PHASE = 17;
	localparam int HOLD_OFF_CYCLES  = 400;

	typedef struct {
		entry_t rec;
		logic   last;
	} drained_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	thn_item_if   item_ch();
	thn_result_if result_ch();

	top_n_largest_min_heap_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch.sink),
		.result    (result_ch.source)
	);

	// Mirror of the heap contents and the capacity register.
	entry_t           kept[MAX_KEPT];
	int               kept_count = 0;
	logic [CFG_W-1:0] kept_capacity = CAP_RESET;
	drained_t         drained_q[$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Timeout: traffic did not complete");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
	                           input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic void swap_kept(input int a, input int b);
		entry_t t;
		t       = kept[a];
		kept[a] = kept[b];
		kept[b] = t;
	endfunction

	// Sift the root down over the first n entries; the left child wins a tie.
	function automatic void sift_kept_down(input int n);
		int i, l, r, best;
		i = 0;
		while (1'b1) begin
			l    = 2 * i + 1;
			r    = 2 * i + 2;
			best = i;
			if (l < n && kept[l].mem_bytes < kept[best].mem_bytes)
				best = l;
			if (r < n && kept[r].mem_bytes < kept[best].mem_bytes)
				best = r;
			if (best == i)
				break;
			swap_kept(best, i);
			i = best;
		end
	endfunction

	function automatic void keep_record(input entry_t rec);
		int limit, i, up;
		limit = (kept_capacity > MAX_KEPT) ? MAX_KEPT : int'(kept_capacity);
		if (kept_count < limit) begin
			i          = kept_count;
			kept[i]    = rec;
			kept_count = kept_count + 1;
			while (i > 0) begin
				up = (i - 1) / 2;
				if (kept[up].mem_bytes <= kept[i].mem_bytes)
					break;
				swap_kept(up, i);
				i = up;
			end
		end else if (kept_count > 0 && rec.mem_bytes > kept[0].mem_bytes) begin
			// A full heap only lets a strictly larger record in, at the root.
			kept[0] = rec;
			sift_kept_down(kept_count);
		end
	endfunction

	function automatic void drain_kept();
		drained_t d;
		while (kept_count > 0) begin
			d.rec      = kept[0];
			d.last     = (kept_count == 1);
			drained_q.push_back(d);
			kept_count = kept_count - 1;
			if (kept_count > 0) begin
				kept[0] = kept[kept_count];
				sift_kept_down(kept_count);
			end
		end
	endfunction

	function automatic entry_t random_record();
		entry_t      r;
		logic [63:0] wide;
		wide              = {$urandom, $urandom};
		r.mem_bytes       = wide[47:0];
		// Small sizes make ties and root replacements common.
		case ($urandom_range(3))
			0: r.mem_bytes = 48'($urandom_range(15));
			1: r.mem_bytes = 48'($urandom_range(4095));
			2: r.mem_bytes = $urandom_range(1) ? {48{1'b1}} : 48'd0;
			default: ;
		endcase
		wide              = {$urandom, $urandom};
		r.expire_ms       = wide[47:0];
		r.key_tag         = $urandom;
		r.db_index        = 8'($urandom);
		r.data_type       = 4'($urandom);
		r.item_count      = $urandom;
		r.largest_element = $urandom;
		r.has_expiry      = 1'($urandom);
		return r;
	endfunction

	function automatic entry_t sized_record(input logic [47:0] size, input logic [31:0] tag);
		entry_t r;
		r           = random_record();
		r.mem_bytes = size;
		r.key_tag   = tag;
		return r;
	endfunction

	task automatic drive_item(input logic offer, input op_t op, input entry_t rec);
		item_ch.valid           <= offer;
		item_ch.opcode          <= op;
		item_ch.mem_bytes       <= rec.mem_bytes;
		item_ch.key_tag         <= rec.key_tag;
		item_ch.db_index        <= rec.db_index;
		item_ch.data_type       <= rec.data_type;
		item_ch.item_count      <= rec.item_count;
		item_ch.largest_element <= rec.largest_element;
		item_ch.has_expiry      <= rec.has_expiry;
		item_ch.expire_ms       <= rec.expire_ms;
	endtask

	// Offers one item and returns at the edge of its transfer, valid still high.
	task automatic send_item(input op_t op, input entry_t rec);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		drive_item(1'b1, op, rec);
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		if (op == OP_INSERT)
			keep_record(rec);
		else
			drain_kept();
	endtask

	task automatic insert_record(input entry_t rec);
		send_item(OP_INSERT, rec);
	endtask

	task automatic request_drain();
		send_item(OP_DRAIN, random_record());
	endtask

	// Stops offering, waits for every pending entry, then lets the block settle.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (drained_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		kept_capacity = value;
		cfg_we        <= 1'b0;
	endtask

	task automatic test_empty_drain();
		request_drain();
	endtask

	task automatic test_field_extremes();
		insert_record('0);
		insert_record('1);
		insert_record(sized_record(48'd5, 32'h0000_00A1));
		insert_record(sized_record(48'd5, 32'h0000_00A2));
		insert_record(sized_record(48'd3, 32'h0000_00A3));
		request_drain();
	endtask

	task automatic test_root_replacement();
		write_capacity(5'd2);
		insert_record(sized_record(48'd10, 32'h0000_00B1));
		insert_record(sized_record(48'd10, 32'h0000_00B2));
		// An equal size must not displace the root of a full heap.
		insert_record(sized_record(48'd10, 32'h0000_00B3));
		insert_record(sized_record(48'd11, 32'h0000_00B4));
		request_drain();
		write_capacity(5'd1);
		insert_record(sized_record(48'd7, 32'h0000_00C1));
		insert_record(sized_record(48'd8, 32'h0000_00C2));
		insert_record(sized_record(48'd6, 32'h0000_00C3));
		request_drain();
	endtask

	task automatic test_capacity_limits();
		write_capacity(5'd31);
		insert_record(sized_record(48'd20, 32'h0000_00D1));
		insert_record(sized_record(48'd21, 32'h0000_00D2));
		insert_record(sized_record(48'd22, 32'h0000_00D3));
		insert_record(sized_record(48'd23, 32'h0000_00D4));
		// Zero capacity with a filled heap still replaces the root.
		write_capacity(5'd0);
		insert_record(sized_record(48'd30, 32'h0000_00D5));
		request_drain();
		insert_record(sized_record(48'd40, 32'h0000_00D6));
		request_drain();
	endtask

	task automatic test_random_traffic();
		int               idle_pct[4];
		int               stall_pct[4];
		logic [CFG_W-1:0] cap_seq[4];
		idle_pct  = '{0, 71, 0, 6};
		stall_pct = '{0, 0, 71, 6};
		cap_seq   = '{5'd16, CFG_W'($urandom_range(15, 2)), 5'd1, 5'd31};
		// Phases do not end with a drain, so a capacity can drop below the count.
		for (int p = 0; p < 4; p++) begin
			write_capacity(cap_seq[p]);
			send_idle_pct  = idle_pct[p];
			recv_stall_pct = stall_pct[p];
			repeat (RANDOM_PER_PHASE) begin
				if ($urandom_range(6) == 0)
					request_drain();
				else
					insert_record(random_record());
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_output_backpressure();
		write_capacity(5'd16);
		repeat (MAX_KEPT) insert_record(random_record());
		hold_left = HOLD_OFF_CYCLES;
		request_drain();
		repeat (8) insert_record(random_record());
		request_drain();
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left       = hold_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_checker
		drained_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (drained_q.size() == 0) begin
				report_mismatch("result transfer with no drained entry pending");
			end else begin
				want = drained_q.pop_front();
				check_field("mem_bytes", 64'(result_ch.out_mem_bytes),
				            64'(want.rec.mem_bytes));
				check_field("key_tag", 64'(result_ch.out_key_tag), 64'(want.rec.key_tag));
				check_field("db_index", 64'(result_ch.out_db_index),
				            64'(want.rec.db_index));
				check_field("data_type", 64'(result_ch.out_data_type),
				            64'(want.rec.data_type));
				check_field("item_count", 64'(result_ch.out_item_count),
				            64'(want.rec.item_count));
				check_field("largest_element", 64'(result_ch.out_largest_element),
				            64'(want.rec.largest_element));
				check_field("has_expiry", 64'(result_ch.out_has_expiry),
				            64'(want.rec.has_expiry));
				check_field("expire_ms", 64'(result_ch.out_expire_ms),
				            64'(want.rec.expire_ms));
				check_field("last", 64'(result_ch.last), 64'(want.last));
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= CAP_RESET;
		drive_item(1'b0, OP_INSERT, '0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_drain();
		test_field_extremes();
		test_root_replacement();
		test_capacity_limits();
		test_random_traffic();
		test_output_backpressure();
		request_drain();

		wait_idle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
rtl/thn_pkg.sv
rtl/thn_item_if.sv
rtl/thn_result_if.sv
rtl/thn_heap_ram.sv
rtl/thn_sift_cmp.sv
rtl/top_n_largest_min_heap_unit.sv
dv/top_n_largest_min_heap_unit_test.sv
